/* sv/assert_macros.svh */
// Assertion helpers used by the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on aclk, disabled while aresetn is low.
`define PQE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication on aclk, disabled while aresetn is low.
`define PQE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, disabled while aresetn is low.
`define PQE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pqe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqe_pkg
// Types and constants of the pending packet queue with expiry.
// ----------------------------------------------------------------------------
package pqe_pkg;

    localparam int COUNT_W = 6;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 3 * DATA_W;
    localparam logic [DATA_W-1:0] MAX_TIMEOUT = 32'h7FFF_FFFF;

    localparam logic [2:0] MODE_ENQ  = 3'd0;
    localparam logic [2:0] MODE_DEQ  = 3'd1;
    localparam logic [2:0] MODE_DROP = 3'd2;
    localparam logic [2:0] MODE_FIND = 3'd3;
    localparam logic [2:0] MODE_SIZE = 3'd4;
    localparam logic [2:0] MODE_TICK = 3'd5;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_EVICTED = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;
    localparam logic [1:0] KIND_FINAL   = 2'd3;

    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE_NEW,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PASS_PURGE,
        PASS_DST,
        PASS_EVICT,
        PASS_FIND
    } pass_t;

endpackage

/* sv/pqe_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqe_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pqe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/pending_packet_queue_with_expiry_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_packet_queue_with_expiry_core
// Ordered packet store with expiry, eviction and per-destination removal.
// ----------------------------------------------------------------------------
// Entries live in one memory, oldest first, and the queue operations work on
// it as scan passes that read each held entry and write the kept ones back
// compacted. Enqueue, dequeue and size make one purge pass; drop by
// destination adds a second pass, enqueue of a new entry adds an eviction
// pass when the store holds the configured maximum length, and find makes
// one pass without removal; tick and unused modes make no pass. Each notice
// waits in the output register until it is taken, which stalls the scan.
// No clearing pass is needed after reset; one input is handled at a time
// and the next is accepted once the final result is registered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pending_packet_queue_with_expiry_core #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_packet_id,
    input  logic [31:0] s_dst_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic        m_ok,
    output logic [31:0] m_out_packet_id,
    output logic [31:0] m_out_dst_addr,
    output logic [5:0]  m_count,
    output logic        m_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = pqe_pkg::DATA_W;

    pqe_pkg::state_t state_reg, state_next;
    pqe_pkg::pass_t  pass_reg, pass_next;

    logic [5:0]    max_len_reg, max_len_next;
    logic [DW-1:0] timeout_reg, timeout_next;
    logic [DW-1:0] now_reg, now_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] evict_reg, evict_next;
    logic          found_reg, found_next;
    logic          dup_reg, dup_next;
    logic [2:0]    mode_reg, mode_next;
    logic [DW-1:0] pid_reg, pid_next;
    logic [DW-1:0] dst_reg, dst_next;
    logic [DW-1:0] oid_reg, oid_next;
    logic [DW-1:0] odst_reg, odst_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_kind_reg, m_kind_next;
    logic          m_ok_reg, m_ok_next;
    logic [DW-1:0] m_id_reg, m_id_next;
    logic [DW-1:0] m_dst_reg, m_dst_next;
    logic [5:0]    m_count_reg, m_count_next;
    logic          m_last_reg, m_last_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [pqe_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [pqe_pkg::ENTRY_W-1:0] ram_rdata;

    logic [DW-1:0] e_id, e_dst, e_exp, t_sat, diff;
    logic [CW-1:0] lim;
    logic          out_free, expired, dst_hit, hit, notify;
    logic [1:0]    hit_kind;

    pqe_ram #(
        .WIDTH(pqe_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == pqe_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_ok            = m_ok_reg;
    assign m_out_packet_id = m_id_reg;
    assign m_out_dst_addr  = m_dst_reg;
    assign m_count         = m_count_reg;
    assign m_last          = m_last_reg;

    assign e_id     = ram_rdata[DW-1:0];
    assign e_dst    = ram_rdata[2*DW-1:DW];
    assign e_exp    = ram_rdata[3*DW-1:2*DW];
    assign diff     = e_exp - now_reg;
    assign expired  = diff[DW-1];
    assign dst_hit  = (e_dst == dst_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign t_sat    = timeout_reg[DW-1] ? pqe_pkg::MAX_TIMEOUT : timeout_reg;

    always_comb begin
        if (max_len_reg == 6'd0) begin
            lim = CW'(1);
        end else if ({1'b0, max_len_reg} > 7'(QUEUE_DEPTH)) begin
            lim = CW'(QUEUE_DEPTH);
        end else begin
            lim = CW'(max_len_reg);
        end
    end

    always_comb begin
        hit      = 1'b0;
        notify   = 1'b0;
        hit_kind = pqe_pkg::KIND_EXPIRED;
        case (pass_reg)
            pqe_pkg::PASS_PURGE: begin
                if (expired) begin
                    hit    = 1'b1;
                    notify = 1'b1;
                end else if (mode_reg == pqe_pkg::MODE_DEQ && !found_reg && dst_hit) begin
                    hit = 1'b1;
                end
            end
            pqe_pkg::PASS_DST: begin
                hit      = dst_hit;
                notify   = dst_hit;
                hit_kind = pqe_pkg::KIND_DROPPED;
            end
            pqe_pkg::PASS_EVICT: begin
                hit      = (rd_reg < evict_reg);
                notify   = hit;
                hit_kind = pqe_pkg::KIND_EVICTED;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        max_len_next = max_len_reg;
        timeout_next = timeout_reg;
        now_next     = now_reg;
        used_next    = used_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        held_next    = held_reg;
        evict_next   = evict_reg;
        found_next   = found_reg;
        dup_next     = dup_reg;
        mode_next    = mode_reg;
        pid_next     = pid_reg;
        dst_next     = dst_reg;
        oid_next     = oid_reg;
        odst_next    = odst_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_ok_next    = m_ok_reg;
        m_id_next    = m_id_reg;
        m_dst_next   = m_dst_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_reg[AW-1:0];
        ram_wdata    = {e_exp, e_dst, e_id};
        ram_raddr    = rd_reg[AW-1:0];

        if (cfg_valid) begin
            if (cfg_index == pqe_pkg::CFG_MAX_LEN) begin
                max_len_next = cfg_data[5:0];
            end else begin
                timeout_next = cfg_data;
            end
        end

        unique case (state_reg)
            pqe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    pid_next   = s_packet_id;
                    dst_next   = s_dst_addr;
                    found_next = 1'b0;
                    dup_next   = 1'b0;
                    oid_next   = '0;
                    odst_next  = '0;
                    rd_next    = '0;
                    wr_next    = '0;
                    held_next  = used_reg;
                    if (s_mode == pqe_pkg::MODE_ENQ || s_mode == pqe_pkg::MODE_DEQ ||
                        s_mode == pqe_pkg::MODE_DROP || s_mode == pqe_pkg::MODE_SIZE) begin
                        pass_next  = pqe_pkg::PASS_PURGE;
                        state_next = pqe_pkg::ST_READ;
                    end else if (s_mode == pqe_pkg::MODE_FIND) begin
                        pass_next  = pqe_pkg::PASS_FIND;
                        state_next = pqe_pkg::ST_READ;
                    end else begin
                        if (s_mode == pqe_pkg::MODE_TICK) begin
                            now_next = now_reg + 32'd1;
                        end
                        state_next = pqe_pkg::ST_FINAL;
                    end
                end
            end
            pqe_pkg::ST_READ: begin
                if (rd_reg == used_reg) begin
                    rd_next   = '0;
                    wr_next   = '0;
                    held_next = used_reg;
                    case (pass_reg)
                        pqe_pkg::PASS_PURGE: begin
                            if (mode_reg == pqe_pkg::MODE_ENQ) begin
                                if (dup_reg) begin
                                    state_next = pqe_pkg::ST_FINAL;
                                end else if (used_reg >= lim) begin
                                    evict_next = used_reg - lim + CW'(1);
                                    pass_next  = pqe_pkg::PASS_EVICT;
                                end else begin
                                    state_next = pqe_pkg::ST_WRITE_NEW;
                                end
                            end else if (mode_reg == pqe_pkg::MODE_DROP) begin
                                pass_next = pqe_pkg::PASS_DST;
                            end else begin
                                state_next = pqe_pkg::ST_FINAL;
                            end
                        end
                        pqe_pkg::PASS_EVICT: begin
                            state_next = pqe_pkg::ST_WRITE_NEW;
                        end
                        default: begin
                            state_next = pqe_pkg::ST_FINAL;
                        end
                    endcase
                end else begin
                    state_next = pqe_pkg::ST_EVAL;
                end
            end
            pqe_pkg::ST_EVAL: begin
                if (!(hit && notify && !out_free)) begin
                    rd_next    = rd_reg + CW'(1);
                    state_next = pqe_pkg::ST_READ;
                    if (hit) begin
                        if (notify) begin
                            held_next    = held_reg - CW'(1);
                            m_valid_next = 1'b1;
                            m_kind_next  = hit_kind;
                            m_ok_next    = 1'b0;
                            m_id_next    = e_id;
                            m_dst_next   = e_dst;
                            m_count_next = 6'(held_reg - CW'(1));
                            m_last_next  = 1'b0;
                        end else begin
                            found_next = 1'b1;
                            oid_next   = e_id;
                            odst_next  = e_dst;
                        end
                    end else begin
                        ram_we  = 1'b1;
                        wr_next = wr_reg + CW'(1);
                        if (pass_reg == pqe_pkg::PASS_PURGE && mode_reg == pqe_pkg::MODE_ENQ &&
                            dst_hit && e_id == pid_reg) begin
                            dup_next = 1'b1;
                        end
                        if (pass_reg == pqe_pkg::PASS_FIND && dst_hit) begin
                            found_next = 1'b1;
                        end
                    end
                    if (rd_reg + CW'(1) == used_reg) begin
                        used_next = hit ? wr_reg : wr_reg + CW'(1);
                        rd_next   = hit ? wr_reg : wr_reg + CW'(1);
                    end
                end
            end
            pqe_pkg::ST_WRITE_NEW: begin
                ram_we     = 1'b1;
                ram_waddr  = used_reg[AW-1:0];
                ram_wdata  = {now_reg + t_sat, dst_reg, pid_reg};
                used_next  = used_reg + CW'(1);
                found_next = 1'b1;
                state_next = pqe_pkg::ST_FINAL;
            end
            pqe_pkg::ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pqe_pkg::KIND_FINAL;
                    m_ok_next    = found_reg;
                    m_id_next    = oid_reg;
                    m_dst_next   = odst_reg;
                    m_count_next = 6'(used_reg);
                    m_last_next  = 1'b1;
                    state_next   = pqe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pqe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pqe_pkg::ST_IDLE;
            pass_reg    <= pqe_pkg::PASS_PURGE;
            max_len_reg <= 6'd32;
            timeout_reg <= 32'd30000;
            now_reg     <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            max_len_reg <= max_len_next;
            timeout_reg <= timeout_next;
            now_reg     <= now_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg      <= rd_next;
        wr_reg      <= wr_next;
        held_reg    <= held_next;
        evict_reg   <= evict_next;
        found_reg   <= found_next;
        dup_reg     <= dup_next;
        mode_reg    <= mode_next;
        pid_reg     <= pid_next;
        dst_reg     <= dst_next;
        oid_reg     <= oid_next;
        odst_reg    <= odst_next;
        m_kind_reg  <= m_kind_next;
        m_ok_reg    <= m_ok_next;
        m_id_reg    <= m_id_next;
        m_dst_reg   <= m_dst_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    `PQE_ASSERT(a_used_bound, used_reg <= CW'(QUEUE_DEPTH), "entry count exceeds depth")
    `PQE_ASSERT_IMP(a_compact_order, state_reg == pqe_pkg::ST_EVAL, wr_reg <= rd_reg, "wr past rd")
    `PQE_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, state_reg != pqe_pkg::ST_IDLE, "no work")
    `PQE_ASSERT_IMP(a_scan_in_range, state_reg == pqe_pkg::ST_EVAL, rd_reg < used_reg, "rd range")

endmodule

/* tb/tb_pending_packet_queue_with_expiry_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pending_packet_queue_with_expiry_core
// Self-checking test of the pending packet queue with expiry. A scoreboard
// class models the ordered store, its purge, eviction and tick counter, and
// checks every result transfer in order against the expected notices and
// final answers.
// ----------------------------------------------------------------------------
module tb_pending_packet_queue_with_expiry_core;
    import pqe_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [31:0] pid;
        logic [31:0] dst;
        logic [5:0]  count;
        logic        last;
    } notice_t;

    class queue_scoreboard;
        logic [31:0] ids[$];
        logic [31:0] dsts[$];
        logic [31:0] exps[$];
        logic [5:0]  max_len;
        logic [31:0] timeout;
        logic [31:0] now;
        notice_t     pending[$];
        int          errors;

        function new();
            max_len = 6'd32;
            timeout = 32'd30000;
            now = 0;
            errors = 0;
        endfunction

        function void configure(logic idx, logic [31:0] data);
            if (idx == CFG_MAX_LEN) max_len = data[5:0];
            else timeout = data;
        endfunction

        function void push(logic [1:0] k, logic o, logic [31:0] p, logic [31:0] d,
                           logic l);
            notice_t n;
            n.kind = k; n.ok = o; n.pid = p; n.dst = d;
            n.count = 6'(ids.size()); n.last = l;
            pending = {pending, n};
        endfunction

        function void sweep(logic by_dst, logic [31:0] d);
            int i;
            logic [31:0] diff;
            logic hit;
            i = 0;
            while (i < ids.size()) begin
                diff = exps[i] - now;
                hit = by_dst ? (dsts[i] == d) : diff[31];
                if (hit) begin
                    logic [31:0] p, q;
                    p = ids[i]; q = dsts[i];
                    ids.delete(i); dsts.delete(i); exps.delete(i);
                    push(by_dst ? KIND_DROPPED : KIND_EXPIRED, 1'b0, p, q, 1'b0);
                end else begin
                    i++;
                end
            end
        endfunction

        function void note_input(logic [2:0] mode, logic [31:0] pid, logic [31:0] dst);
            logic ok;
            logic [31:0] oid, odst, t;
            int lim;
            ok = 0; oid = 0; odst = 0;
            if (mode <= MODE_DROP || mode == MODE_SIZE) sweep(1'b0, 0);
            case (mode)
                MODE_ENQ: begin
                    foreach (ids[i]) if (ids[i] == pid && dsts[i] == dst) ok = 1;
                    if (ok) begin
                        ok = 0;
                    end else begin
                        lim = max_len;
                        if (lim < 1) lim = 1;
                        if (lim > 32) lim = 32;
                        t = (timeout > MAX_TIMEOUT) ? MAX_TIMEOUT : timeout;
                        while (ids.size() >= lim && ids.size() > 0) begin
                            logic [31:0] p, q;
                            p = ids.pop_front(); q = dsts.pop_front();
                            void'(exps.pop_front());
                            push(KIND_EVICTED, 1'b0, p, q, 1'b0);
                        end
                        ids = {ids, pid}; dsts = {dsts, dst};
                        exps = {exps, now + t};
                        ok = 1;
                    end
                end
                MODE_DEQ: begin
                    for (int i = 0; i < ids.size(); i++) begin
                        if (dsts[i] == dst) begin
                            oid = ids[i]; odst = dsts[i];
                            ids.delete(i); dsts.delete(i); exps.delete(i);
                            ok = 1;
                            break;
                        end
                    end
                end
                MODE_DROP: sweep(1'b1, dst);
                MODE_FIND: foreach (dsts[i]) if (dsts[i] == dst) ok = 1;
                MODE_TICK: now = now + 1;
                default: ;
            endcase
            push(KIND_FINAL, ok, oid, odst, 1'b1);
        endfunction

        function void check_result(notice_t got);
            notice_t e;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, got.kind); errors++;
            end
            if (got.ok !== e.ok) begin
                $error("ok: expected %0d, actual %0d", e.ok, got.ok); errors++;
            end
            if (got.pid !== e.pid) begin
                $error("out_packet_id: expected %h, actual %h", e.pid, got.pid); errors++;
            end
            if (got.dst !== e.dst) begin
                $error("out_dst_addr: expected %h, actual %h", e.dst, got.dst); errors++;
            end
            if (got.count !== e.count) begin
                $error("count: expected %0d, actual %0d", e.count, got.count); errors++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_mode = 0;
    logic [31:0] s_packet_id = 0;
    logic [31:0] s_dst_addr = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_kind;
    logic        m_ok;
    logic [31:0] m_out_packet_id;
    logic [31:0] m_out_dst_addr;
    logic [5:0]  m_count;
    logic        m_last;

    queue_scoreboard board = new();
    int  hold_off = 0;
    bit  rx_quiet = 0;
    logic [31:0] dst_pool[4];
    logic [31:0] id_pool[4];

    pending_packet_queue_with_expiry_core i_dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result({m_kind, m_ok, m_out_packet_id, m_out_dst_addr,
                                m_count, m_last});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else if (rx_quiet) begin
            m_ready <= 1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_cfg(logic idx, logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.configure(idx, data);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic send(logic [2:0] mode, logic [31:0] pid, logic [31:0] dst);
        s_valid <= 1;
        s_mode <= mode;
        s_packet_id <= pid;
        s_dst_addr <= dst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(mode, pid, dst);
    endtask

    task automatic pause(int n);
        s_valid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        pause(1);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_item();
        int r;
        logic [2:0] mode;
        r = $urandom_range(0, 99);
        if (r < 40) mode = MODE_ENQ;
        else if (r < 52) mode = MODE_DEQ;
        else if (r < 60) mode = MODE_DROP;
        else if (r < 68) mode = MODE_FIND;
        else if (r < 74) mode = MODE_SIZE;
        else if (r < 96) mode = MODE_TICK;
        else mode = 3'($urandom_range(6, 7));
        send(mode,
             ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 3)],
             ($urandom_range(0, 9) == 0) ? $urandom() : dst_pool[$urandom_range(0, 3)]);
    endtask

    task automatic random_phase(int items);
        int burst;
        while (items > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && items > 0) begin
                random_item();
                burst--; items--;
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
        end
    endtask

    initial begin
        foreach (dst_pool[i]) begin
            dst_pool[i] = $urandom();
            id_pool[i] = $urandom();
        end
        dst_pool[0] = 32'hFFFF_FFFF;
        id_pool[0] = 32'h0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: extremes, each mode, duplicates, expiry, unused modes.
        rx_quiet = 1;
        write_cfg(CFG_MAX_LEN, 32'd2);
        write_cfg(CFG_TIMEOUT, 32'd0);
        send(MODE_ENQ, 32'h0, 32'h0);
        send(MODE_ENQ, 32'h0, 32'h0);
        send(MODE_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(MODE_ENQ, 32'h1234_5678, 32'hFFFF_FFFF);
        send(MODE_FIND, 0, 32'hFFFF_FFFF);
        send(MODE_TICK, 0, 0);
        send(MODE_FIND, 0, 32'hFFFF_FFFF);
        send(MODE_SIZE, 0, 0);
        send(MODE_DEQ, 0, 32'hFFFF_FFFF);
        send(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(3'd7, 0, 0);
        drain();
        write_cfg(CFG_MAX_LEN, 32'd0);
        write_cfg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send(MODE_ENQ, 32'd1, 32'd5);
        send(MODE_ENQ, 32'd2, 32'd5);
        send(MODE_TICK, 0, 0);
        drain();
        write_cfg(CFG_MAX_LEN, 32'd63);
        send(MODE_ENQ, 32'd3, 32'd5);
        send(MODE_ENQ, 32'd4, 32'd6);
        send(MODE_ENQ, 32'd5, 32'd5);
        send(MODE_DROP, 0, 32'd5);
        send(MODE_DEQ, 0, 32'd6);
        send(MODE_DEQ, 0, 32'd6);
        drain();
        rx_quiet = 0;

        // Random phases across several settings.
        write_cfg(CFG_MAX_LEN, 32'd32);
        write_cfg(CFG_TIMEOUT, 32'd6);
        random_phase(90);
        drain();
        write_cfg(CFG_MAX_LEN, 32'd1);
        write_cfg(CFG_TIMEOUT, 32'd2);
        random_phase(50);
        drain();
        write_cfg(CFG_MAX_LEN, 32'd5);
        write_cfg(CFG_TIMEOUT, 32'h8000_0000);
        hold_off = 400;
        random_phase(40);
        drain();
        write_cfg(CFG_MAX_LEN, 32'd40);
        write_cfg(CFG_TIMEOUT, 32'd25);
        random_phase(120);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* pending_packet_queue_with_expiry_core.f */
+incdir+sv
sv/pqe_pkg.sv
sv/pqe_ram.sv
sv/pending_packet_queue_with_expiry_core.sv
tb/tb_pending_packet_queue_with_expiry_core.sv
